// ===== sv/ppe_pkg.sv =====
// Shared types and constants for the particle pool engine.
package ppe_pkg;

	typedef enum logic [1:0] {
		FUNC_SPAWN = 2'd0,
		FUNC_TICK  = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_READ  = 2'd3
	} func_t;

	localparam int unsigned ADDR_FPS = 0;
	localparam logic [7:0] FPS_RESET = 8'd60;
	localparam logic [8:0] ALPHA_ONE = 9'd256;

	// One particle record as kept in the entry memory.
	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [23:0] vx;
		logic signed [23:0] vy;
		logic [15:0] grav;
		logic [16:0] life_left;
		logic [16:0] life_full;
		logic [11:0] base_size;
		logic [11:0] cur_size;
		logic [8:0] alpha;
	} part_t;

	// Handshake between the sequencer and the ratio divider.
	typedef struct packed {
		logic start;
		logic [28:0] num_size;
		logic [24:0] num_alpha;
		logic [16:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [11:0] size;
		logic [8:0] alpha;
	} div_rsp_t;

endpackage

// ===== sv/particle_pool_engine.sv =====
// Top level of the particle pool engine: request sequencer and entry memory.
//
//  channel   | valid      | stall      | payload
//  request   | in_valid   | in_stall   | func, spawn_*, tick_time, read_index
//  result    | out_valid  | out_stall  | slot, pool_full, active_count, out_*
//  config    | psel       | -          | paddr, pwdata (APB, pready always high)
//
// Spawn scans one slot per cycle up to the lowest free one; read goes via ST_WAIT, clear
// directly; every request ends in ST_RPT and ST_OUT. Tick takes each active slot through
// ST_RD, ST_MUL, ST_ADD, ST_DIV, ST_WAIT (serial divider) and ST_WB, skipping ST_WAIT
// when its full life is zero, and idle slots through ST_RD only. One request at a time.
// Reset clears the active flags and the control state; entry data is undefined.
// A waiting result stalls only the output register and ST_OUT; the next request is still taken.
module particle_pool_engine
	import ppe_pkg::*;
#(
	parameter int unsigned POOL_SIZE = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic signed [31:0] spawn_x,
	input  logic signed [31:0] spawn_y,
	input  logic signed [23:0] spawn_vx,
	input  logic signed [23:0] spawn_vy,
	input  logic [15:0]        spawn_gravity,
	input  logic [16:0]        spawn_life,
	input  logic [11:0]        spawn_size,
	input  logic [8:0]         spawn_alpha,
	input  logic [15:0]        tick_time,
	input  logic [6:0]         read_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [6:0]         slot,
	output logic               pool_full,
	output logic [7:0]         active_count,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic [11:0]        out_size,
	output logic [8:0]         out_alpha,
	output logic               out_active,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [0:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int unsigned IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int unsigned CW = $clog2(POOL_SIZE + 1);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_SCAN  = 10'b0000000010,
		ST_RD    = 10'b0000000100,
		ST_MUL   = 10'b0000001000,
		ST_ADD   = 10'b0000010000,
		ST_DIV   = 10'b0000100000,
		ST_WAIT  = 10'b0001000000,
		ST_WB    = 10'b0010000000,
		ST_RPT   = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [7:0] fps_q;

	part_t mem [POOL_SIZE];
	part_t rd_q;
	logic [IW-1:0] raddr;
	logic [IW-1:0] waddr;
	logic          wen;
	part_t         wdata;
	logic [POOL_SIZE-1:0] act_q;
	logic [CW-1:0] cnt_q;

	logic [1:0]  func_q;
	part_t       sp_q;
	logic [15:0] t_q;
	logic [6:0]  ridx_q;
	logic [IW-1:0] idx_q;
	logic [23:0] s_q;
	logic signed [63:0] mx_s1, my_s1;
	logic [39:0] mg_s1;
	part_t       upd_q;
	part_t       upd_d;
	logic        alive_q;

	div_req_t dreq;
	div_rsp_t drsp;

	ppe_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign pready = 1'b1;
	assign prdata = {24'd0, fps_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fps_q <= FPS_RESET;
		else if (psel && penable && pwrite && paddr == 1'(ADDR_FPS)) fps_q <= pwdata[7:0];
	end

	always_ff @(posedge clk) begin
		if (wen) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	logic in_acc;
	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign raddr    = idx_q;

	// Arithmetic helpers for the tick update.
	logic signed [63:0] nx, ny;
	logic signed [40:0] gv;
	logic [16:0] left;
	function automatic logic signed [63:0] fshr16(input logic signed [63:0] v);
		fshr16 = v >>> 16;
	endfunction
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) sat32 = 32'sh7fffffff;
		else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
		else sat32 = v[31:0];
	endfunction
	always_comb begin
		nx   = 64'(rd_q.px) + fshr16(mx_s1);
		ny   = 64'(rd_q.py) + fshr16(my_s1);
		gv   = 41'(rd_q.vy) + 41'(mg_s1 >> 16);
		left = (rd_q.life_left > 17'(t_q)) ? rd_q.life_left - 17'(t_q) : 17'd0;
		upd_d = rd_q;
		if (fps_q != 8'd0) begin
			upd_d.px = sat32(nx);
			upd_d.py = sat32(ny);
			upd_d.vy = (gv > 41'sd8388607) ? 24'sh7fffff : gv[23:0];
		end
		upd_d.life_left = left;
	end

	always_comb begin
		dreq.start     = (state_q == ST_DIV) && (upd_q.life_full != 17'd0);
		dreq.num_size  = 29'(upd_q.base_size) * 29'(upd_q.life_left);
		dreq.num_alpha = {upd_q.life_left, 8'd0};
		dreq.den       = upd_q.life_full;
		wen   = 1'b0;
		waddr = idx_q;
		wdata = upd_q;
		if (state_q == ST_SCAN && !act_q[idx_q] && func_q == FUNC_SPAWN) begin
			wen   = 1'b1;
			wdata = sp_q;
		end
		if (state_q == ST_WB) begin
			wen = 1'b1;
		end
	end

	logic [6:0]  o_slot;
	logic        o_full;
	logic signed [31:0] o_x, o_y;
	logic [11:0] o_size;
	logic [8:0]  o_alpha;
	logic        o_act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			act_q     <= '0;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall && state_q != ST_OUT) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_acc) begin
					unique case (func_t'(func))
						FUNC_SPAWN: begin
							idx_q <= '0; state_q <= ST_SCAN;
						end
						FUNC_TICK: begin
							idx_q <= '0; state_q <= ST_RD;
						end
						FUNC_CLEAR: begin
							act_q <= '0; cnt_q <= '0; state_q <= ST_RPT;
						end
						FUNC_READ: begin
							idx_q <= IW'(read_index);
							state_q <= (32'(read_index) < POOL_SIZE) ? ST_WAIT : ST_RPT;
						end
						default: state_q <= ST_RPT;
					endcase
				end
				ST_SCAN: begin
					if (!act_q[idx_q]) begin
						act_q[idx_q] <= 1'b1;
						cnt_q <= cnt_q + 1'b1;
						state_q <= ST_RPT;
					end else if (32'(idx_q) == POOL_SIZE - 1) begin
						state_q <= ST_RPT;
					end else idx_q <= idx_q + 1'b1;
				end
				ST_RD: begin
					// Memory read for idx_q is issued this cycle.
					if (act_q[idx_q]) state_q <= ST_MUL;
					else if (32'(idx_q) == POOL_SIZE - 1) state_q <= ST_RPT;
					else idx_q <= idx_q + 1'b1;
				end
				ST_MUL: begin
					mx_s1 <= 64'(rd_q.vx) * $signed({1'b0, s_q});
					my_s1 <= 64'(rd_q.vy) * $signed({1'b0, s_q});
					mg_s1 <= 40'(rd_q.grav) * 40'(s_q);
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					upd_q <= upd_d;
					alive_q <= (left != 17'd0);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (upd_q.life_full == 17'd0) begin
						upd_q.cur_size <= '0; upd_q.alpha <= '0; state_q <= ST_WB;
					end else state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (func_q == FUNC_READ) state_q <= ST_RPT;
					else if (drsp.done) begin
						upd_q.cur_size <= drsp.size;
						upd_q.alpha    <= drsp.alpha;
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (!alive_q) begin
						act_q[idx_q] <= 1'b0; cnt_q <= cnt_q - 1'b1;
					end
					if (32'(idx_q) == POOL_SIZE - 1) state_q <= ST_RPT;
					else begin
						idx_q <= idx_q + 1'b1; state_q <= ST_RD;
					end
				end
				ST_RPT: state_q <= ST_OUT;
				ST_OUT: if (!out_valid || !out_stall) begin
					out_valid    <= 1'b1;
					slot         <= o_slot;
					pool_full    <= o_full;
					active_count <= 8'(cnt_q);
					out_x        <= o_x;
					out_y        <= o_y;
					out_size     <= o_size;
					out_alpha    <= o_alpha;
					out_active   <= o_act;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload capture at acceptance; spawn record is prebuilt for the write.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			func_q <= func;
			t_q    <= tick_time;
			s_q    <= 24'(tick_time) * 24'(fps_q);
			ridx_q <= read_index;
			sp_q.px <= spawn_x;  sp_q.py <= spawn_y;
			sp_q.vx <= spawn_vx; sp_q.vy <= spawn_vy;
			sp_q.grav <= spawn_gravity;
			sp_q.life_left <= spawn_life; sp_q.life_full <= spawn_life;
			sp_q.base_size <= spawn_size; sp_q.cur_size <= spawn_size;
			sp_q.alpha <= (spawn_alpha > ALPHA_ONE) ? ALPHA_ONE : spawn_alpha;
		end
	end

	logic hit_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) hit_q <= !act_q[idx_q];
		else if (state_q == ST_IDLE) hit_q <= 1'b0;
	end

	always_comb begin
		o_slot = '0; o_full = 1'b0; o_x = '0; o_y = '0;
		o_size = '0; o_alpha = '0; o_act = 1'b0;
		if (func_q == FUNC_SPAWN) begin
			if (hit_q) begin
				o_slot = 7'(idx_q); o_x = sp_q.px; o_y = sp_q.py;
				o_size = sp_q.cur_size; o_alpha = sp_q.alpha; o_act = 1'b1;
			end else o_full = 1'b1;
		end else if (func_q == FUNC_READ) begin
			o_slot = ridx_q;
			if (32'(ridx_q) < POOL_SIZE) begin
				o_x = rd_q.px; o_y = rd_q.py; o_size = rd_q.cur_size;
				o_alpha = rd_q.alpha; o_act = act_q[idx_q];
			end
		end
	end

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= POOL_SIZE) else $error("count overflow");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall) else $error("request taken while busy");

endmodule

// ===== sv/ppe_div.sv =====
// Restoring divider producing scaled size and opacity, one quotient bit per cycle.
module ppe_div
	import ppe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int unsigned NB = 29;

	logic [4:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [NB-1:0] qa_q;
	logic [24:0]   qb_q;
	logic [17:0]   ra_q;
	logic [17:0]   rb_q;
	logic [16:0]   den_q;
	logic [17:0]   ta;
	logic [17:0]   tb;

	assign ta = {ra_q[16:0], qa_q[NB-1]};
	assign tb = {rb_q[16:0], qb_q[24]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Both quotients run side by side; the opacity quotient uses only the last 25 steps.
	always_ff @(posedge clk) begin
		if (req.start) begin
			qa_q  <= req.num_size;
			qb_q  <= req.num_alpha;
			ra_q  <= '0;
			rb_q  <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (ta >= {1'b0, den_q}) begin
				ra_q <= ta - {1'b0, den_q};
				qa_q <= {qa_q[NB-2:0], 1'b1};
			end else begin
				ra_q <= ta;
				qa_q <= {qa_q[NB-2:0], 1'b0};
			end
			if (cnt_q <= 5'd25) begin
				if (tb >= {1'b0, den_q}) begin
					rb_q <= tb - {1'b0, den_q};
					qb_q <= {qb_q[23:0], 1'b1};
				end else begin
					rb_q <= tb;
					qb_q <= {qb_q[23:0], 1'b0};
				end
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.size  = qa_q[11:0];
	assign rsp.alpha = qb_q[8:0];

endmodule

// ===== tb/particle_pool_engine_tb.sv =====
// Self-checking testbench for the particle pool engine: randomized requests against a model.
`timescale 1ns / 1ps

module particle_pool_engine_tb;
	import ppe_pkg::*;

	localparam int NSLOT = 128;
	localparam longint CYCLE_LIMIT = 40_000_000;

	typedef struct {
		func_t f;
		logic signed [31:0] x, y;
		logic signed [23:0] vx, vy;
		logic [15:0] grav;
		logic [16:0] life;
		logic [11:0] size;
		logic [8:0] alpha;
		logic [15:0] dt;
		logic [6:0] idx;
		bit any_slot;
	} request_t;

	typedef struct {
		logic [6:0] slot;
		logic full;
		logic [7:0] count;
		logic signed [31:0] x, y;
		logic [11:0] size;
		logic [8:0] alpha;
		logic act;
	} outcome_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [1:0] func;
	logic signed [31:0] spawn_x, spawn_y, out_x, out_y;
	logic signed [23:0] spawn_vx, spawn_vy;
	logic [15:0] spawn_gravity, tick_time;
	logic [16:0] spawn_life;
	logic [11:0] spawn_size, out_size;
	logic [8:0] spawn_alpha, out_alpha;
	logic [6:0] read_index, slot;
	logic pool_full, out_active;
	logic [7:0] active_count;
	logic psel, penable, pwrite, pready;
	logic [0:0] paddr;
	logic [31:0] pwdata, prdata;

	particle_pool_engine uut (.*);

	request_t pending_reqs[$];
	outcome_t expected_outcomes[$];
	bit failed = 0;
	longint cycle = 0;

	// Mirror of the particle pool.
	logic [7:0] fps_m;
	bit alive[NSLOT];
	bit ever_spawned[NSLOT];
	logic signed [31:0] pos_x[NSLOT], pos_y[NSLOT];
	logic signed [23:0] vel_x[NSLOT], vel_y[NSLOT];
	logic [15:0] grav_m[NSLOT];
	logic [16:0] left_m[NSLOT], full_m[NSLOT];
	logic [11:0] base_m[NSLOT], cur_m[NSLOT];
	logic [8:0] alpha_m[NSLOT];

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [23:0] clamp24(longint v);
		if (v > 64'sd8388607) return 24'h7fffff;
		if (v < -64'sd8388608) return 24'h800000;
		return v[23:0];
	endfunction

	function automatic void fill_report(ref outcome_t o, input int i);
		o.x = pos_x[i];
		o.y = pos_y[i];
		o.size = cur_m[i];
		o.alpha = alpha_m[i];
		o.act = alive[i];
	endfunction

	function automatic void advance_pool(logic [15:0] dt);
		longint s, dx, dy, dg;
		longint unsigned left;
		s = longint'(dt) * longint'(fps_m);
		for (int i = 0; i < NSLOT; i++) begin
			if (!alive[i]) continue;
			dx = (longint'(vel_x[i]) * s) >>> 16;
			dy = (longint'(vel_y[i]) * s) >>> 16;
			pos_x[i] = clamp32(longint'(pos_x[i]) + dx);
			pos_y[i] = clamp32(longint'(pos_y[i]) + dy);
			dg = (longint'(grav_m[i]) * s) >>> 16;
			vel_y[i] = clamp24(longint'(vel_y[i]) + dg);
			left = (left_m[i] > dt) ? 64'(left_m[i] - dt) : 64'd0;
			left_m[i] = left[16:0];
			if (left == 0) alive[i] = 0;
			if (full_m[i] == 0) begin
				cur_m[i] = 0;
				alpha_m[i] = 0;
			end else begin
				cur_m[i] = 12'((longint'(base_m[i]) * left) / full_m[i]);
				alpha_m[i] = 9'((256 * left) / full_m[i]);
			end
		end
	endfunction

	function automatic outcome_t apply_request(request_t r);
		outcome_t o;
		int i, n;
		o = '{default: 0};
		case (r.f)
			FUNC_SPAWN: begin
				for (i = 0; i < NSLOT; i++) if (!alive[i]) break;
				if (i == NSLOT) o.full = 1;
				else begin
					pos_x[i] = r.x;
					pos_y[i] = r.y;
					vel_x[i] = r.vx;
					vel_y[i] = r.vy;
					grav_m[i] = r.grav;
					full_m[i] = r.life;
					left_m[i] = r.life;
					base_m[i] = r.size;
					cur_m[i] = r.size;
					alpha_m[i] = (r.alpha > ALPHA_ONE) ? ALPHA_ONE : r.alpha;
					alive[i] = 1;
					ever_spawned[i] = 1;
					o.slot = i[6:0];
					fill_report(o, i);
				end
			end
			FUNC_TICK: advance_pool(r.dt);
			FUNC_CLEAR: foreach (alive[k]) alive[k] = 0;
			FUNC_READ: begin
				o.slot = r.idx;
				fill_report(o, r.idx);
			end
		endcase
		n = 0;
		foreach (alive[k]) n += alive[k];
		o.count = n[7:0];
		return o;
	endfunction

	// A read with a free index is pointed at a slot written already, or becomes a clear if none is.
	function automatic request_t resolve_read(request_t r);
		int written[$];
		if (r.f != FUNC_READ || !r.any_slot) return r;
		foreach (ever_spawned[k]) if (ever_spawned[k]) written.push_back(k);
		if (written.size() == 0) r.f = FUNC_CLEAR;
		else r.idx = 7'(written[$urandom_range(written.size() - 1)]);
		return r;
	endfunction

	function automatic bit quiet_stretch();
		return (cycle % 60000) < 8000;
	endfunction

	always @(posedge clk) cycle <= cycle + 1;

	always @(posedge clk or negedge arst_n) begin
		request_t r;
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_outcomes.push_back(apply_request(r));
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() > 0 &&
				    (quiet_stretch() || $urandom_range(99) >= 23)) begin
					r = resolve_read(pending_reqs.pop_front());
					func <= r.f;
					spawn_x <= r.x;
					spawn_y <= r.y;
					spawn_vx <= r.vx;
					spawn_vy <= r.vy;
					spawn_gravity <= r.grav;
					spawn_life <= r.life;
					spawn_size <= r.size;
					spawn_alpha <= r.alpha;
					tick_time <= r.dt;
					read_index <= r.idx;
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_stall <= 0;
		else out_stall <= !quiet_stretch() && ($urandom_range(99) < 23);
	end

	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_outcomes.size() == 0) begin
				$error("result with no request outstanding");
				failed = 1;
			end else begin
				e = expected_outcomes.pop_front();
				if (slot !== e.slot) begin
					$error("slot expected %0d got %0d", e.slot, slot); failed = 1;
				end
				if (pool_full !== e.full) begin
					$error("pool_full expected %0d got %0d", e.full, pool_full); failed = 1;
				end
				if (active_count !== e.count) begin
					$error("active_count expected %0d got %0d", e.count, active_count);
					failed = 1;
				end
				if (out_x !== e.x) begin
					$error("out_x expected %0d got %0d", e.x, out_x); failed = 1;
				end
				if (out_y !== e.y) begin
					$error("out_y expected %0d got %0d", e.y, out_y); failed = 1;
				end
				if (out_size !== e.size) begin
					$error("out_size expected %0d got %0d", e.size, out_size); failed = 1;
				end
				if (out_alpha !== e.alpha) begin
					$error("out_alpha expected %0d got %0d", e.alpha, out_alpha); failed = 1;
				end
				if (out_active !== e.act) begin
					$error("out_active expected %0d got %0d", e.act, out_active); failed = 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle >= CYCLE_LIMIT) begin
			$display("particle_pool_engine regression: fail");
			$finish;
		end
	end

	function automatic request_t blank_request(func_t f);
		request_t r;
		r = '{f: f, default: 0};
		return r;
	endfunction

	function automatic void queue_spawn(logic [31:0] x, logic [31:0] y, logic [23:0] vx,
			logic [23:0] vy, logic [15:0] g, logic [16:0] life, logic [11:0] sz,
			logic [8:0] a);
		request_t r;
		r = blank_request(FUNC_SPAWN);
		r.x = x; r.y = y; r.vx = vx; r.vy = vy; r.grav = g;
		r.life = life; r.size = sz; r.alpha = a;
		pending_reqs.push_back(r);
	endfunction

	function automatic void queue_random_spawn(bit long_lived);
		logic [16:0] life;
		if (long_lived) life = 17'(17'h1ffff - $urandom_range(255));
		else if ($urandom_range(3) == 0) life = 17'($urandom_range(131071));
		else life = 17'($urandom_range(1, 20000));
		queue_spawn($urandom, $urandom, 24'($urandom), 24'($urandom), 16'($urandom), life,
			12'($urandom), 9'($urandom_range(511)));
	endfunction

	function automatic void queue_tick(logic [15:0] dt);
		request_t r;
		r = blank_request(FUNC_TICK);
		r.dt = dt;
		pending_reqs.push_back(r);
	endfunction

	function automatic void queue_read();
		request_t r;
		r = blank_request(FUNC_READ);
		r.any_slot = 1;
		pending_reqs.push_back(r);
	endfunction

	function automatic void queue_mix(int n);
		int c;
		for (int k = 0; k < n; k++) begin
			c = $urandom_range(99);
			if (c < 40) queue_random_spawn(0);
			else if (c < 62)
				queue_tick(16'($urandom_range(3) == 0 ? $urandom : $urandom_range(4000)));
			else if (c < 93) queue_read();
			else pending_reqs.push_back(blank_request(FUNC_CLEAR));
		end
	endfunction

	// Spawns past the pool's capacity, ages the full pool, reads six written slots, then clears.
	function automatic void queue_fill_pool();
		for (int k = 0; k < NSLOT + 3; k++) queue_random_spawn(1);
		queue_tick(16'($urandom_range(200)));
		for (int k = 0; k < 6; k++) queue_read();
		pending_reqs.push_back(blank_request(FUNC_CLEAR));
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || in_valid || expected_outcomes.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_fps(logic [7:0] v);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= 1'(ADDR_FPS); pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		fps_m = v;
		@(posedge clk);
	endtask

	initial begin
		request_t r;
		fps_m = FPS_RESET;
		foreach (alive[k]) begin
			alive[k] = 0;
			ever_spawned[k] = 0;
		end
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; out_stall = 0;
		func = 0; spawn_x = 0; spawn_y = 0; spawn_vx = 0; spawn_vy = 0;
		spawn_gravity = 0; spawn_life = 0; spawn_size = 0; spawn_alpha = 0;
		tick_time = 0; read_index = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// Field extremes, zero full life and opacity above one.
		queue_spawn(32'h7fffffff, 32'h80000000, 24'h7fffff, 24'h800000, 16'hffff,
			17'h1ffff, 12'hfff, 9'd256);
		queue_spawn(32'h80000000, 32'h7fffffff, 24'h800000, 24'h7fffff, 16'h0,
			17'd0, 12'h0, 9'h1ff);
		queue_spawn(0, 0, 0, 0, 16'h0100, 17'd1, 12'h800, 9'd0);
		queue_spawn(32'h00001234, 32'hffffff00, 24'h000100, 24'hffff00, 16'h0040,
			17'd40000, 12'h3ff, 9'd257);
		for (int k = 0; k < 4; k++) begin
			r = blank_request(FUNC_READ);
			r.idx = 7'(k);
			pending_reqs.push_back(r);
		end
		queue_tick(16'd0);
		queue_tick(16'hffff);
		for (int k = 0; k < 4; k++) begin
			r = blank_request(FUNC_READ);
			r.idx = 7'(k);
			pending_reqs.push_back(r);
		end
		pending_reqs.push_back(blank_request(FUNC_CLEAR));
		queue_read();
		queue_tick(16'd100);
		wait_drained();

		write_fps(8'd255);
		queue_mix(350);
		queue_fill_pool();
		wait_drained();

		write_fps(8'd1);
		queue_mix(350);
		wait_drained();

		// Zero frame rate: particles age but do not move.
		write_fps(8'd0);
		queue_mix(200);
		wait_drained();

		write_fps(8'd170);
		queue_mix(250);
		queue_fill_pool();
		wait_drained();

		write_fps(FPS_RESET);
		queue_mix(100);
		wait_drained();

		if (!failed) $display("particle_pool_engine regression: pass");
		else $display("particle_pool_engine regression: fail");
		$finish;
	end

endmodule

// ===== particle_pool_engine.f =====
sv/ppe_pkg.sv
sv/ppe_div.sv
sv/particle_pool_engine.sv
tb/particle_pool_engine_tb.sv
